// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Antecedent on one edge implies consequent on the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bga_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bga_pkg
// Types and constants shared by the button gesture / alarm blinker block.
// ----------------------------------------------------------------------------
package bga_pkg;

  // Operation codes carried by an input beat
  typedef enum logic [1:0] {
    OP_TICK        = 2'd0,
    OP_CONSUME     = 2'd1,
    OP_ALARM_START = 2'd2,
    OP_ALARM_STOP  = 2'd3
  } op_e_t;

  // Pending gesture codes
  typedef enum logic [1:0] {
    KEY_NONE   = 2'd0,
    KEY_SINGLE = 2'd1,
    KEY_LONG   = 2'd2,
    KEY_MULTI  = 2'd3
  } key_e_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_SETTLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTI_PRESS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF    = 3'd4;

  // Reset values of the configuration registers
  localparam logic [7:0] RST_MIN_PRESS      = 8'd2;
  localparam logic [7:0] RST_LONG_PRESS     = 8'd19;
  localparam logic [7:0] RST_RELEASE_SETTLE = 8'd20;
  localparam logic [7:0] RST_MULTI_PRESS    = 8'd3;
  localparam logic [7:0] RST_BLINK_HALF     = 8'd12;

  typedef struct packed {
    op_e_t operation;
    logic  button_low;
    logic  clear_count;
  } in_t;

  typedef struct packed {
    key_e_t     key_event;
    logic [7:0] press_count;
    logic       led_on;
    logic       buzzer_on;
  } out_t;

  typedef struct packed {
    logic [7:0] min_press_ticks;
    logic [7:0] long_press_ticks;
    logic [7:0] release_settle_ticks;
    logic [7:0] multi_press_count;
    logic [7:0] blink_half_period;
  } cfg_t;

  // Saturating 8-bit increment
  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

// ===== rtl/core/bga_gesture.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bga_gesture
// Button hold/release timing, press counting and gesture classification.
// Outputs show the state as it will be after the current beat.
// ----------------------------------------------------------------------------
module bga_gesture (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  bga_pkg::in_t        item,
  input  bga_pkg::cfg_t       cfg,
  output bga_pkg::key_e_t     key_event_nxt,
  output logic [7:0]          presses_nxt
);

  logic            was_pressed_r, was_pressed_nxt;
  logic [7:0]      held_r, held_nxt;
  logic [7:0]      released_r, released_nxt;
  logic [7:0]      presses_r;
  bga_pkg::key_e_t pending_r;
  logic [7:0]      rel_inc;

  // Next state for the button tracker
  always_comb begin
    was_pressed_nxt = was_pressed_r;
    held_nxt        = held_r;
    released_nxt    = released_r;
    presses_nxt     = presses_r;
    key_event_nxt   = pending_r;
    rel_inc         = bga_pkg::sat_inc(released_r);
    case (item.operation)
      bga_pkg::OP_TICK: begin
        if (!item.button_low) begin
          // pressed: extend or start the hold count
          held_nxt        = was_pressed_r ? bga_pkg::sat_inc(held_r) : 8'd1;
          was_pressed_nxt = 1'b1;
        end else begin
          was_pressed_nxt = 1'b0;
          if (was_pressed_r) begin
            // release edge: qualify the press
            if (held_r > cfg.min_press_ticks) presses_nxt = bga_pkg::sat_inc(presses_r);
            released_nxt = 8'd0;
          end else begin
            released_nxt = rel_inc;
            if (rel_inc > cfg.release_settle_ticks) begin
              // release settled: classify, later checks override
              if (held_r > cfg.long_press_ticks) begin
                key_event_nxt = bga_pkg::KEY_LONG;
                held_nxt      = 8'd0;
              end else begin
                if (presses_r == 8'd1) key_event_nxt = bga_pkg::KEY_SINGLE;
                if (presses_r >= cfg.multi_press_count) key_event_nxt = bga_pkg::KEY_MULTI;
              end
              released_nxt = bga_pkg::sat_inc(cfg.release_settle_ticks);
            end
          end
        end
      end
      bga_pkg::OP_CONSUME: begin
        key_event_nxt = bga_pkg::KEY_NONE;
        if (item.clear_count) presses_nxt = 8'd0;
      end
      default: ;
    endcase
  end

  // State registers, advanced once per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_pressed_r <= 1'b0;
      held_r        <= 8'd0;
      released_r    <= 8'd0;
      presses_r     <= 8'd0;
      pending_r     <= bga_pkg::KEY_NONE;
    end else if (step) begin
      was_pressed_r <= was_pressed_nxt;
      held_r        <= held_nxt;
      released_r    <= released_nxt;
      presses_r     <= presses_nxt;
      pending_r     <= key_event_nxt;
    end
  end

endmodule

// ===== rtl/core/bga_blink.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bga_blink
// Alarm blinker: countdown that toggles the lamp every half period.
// Output shows the lamp level after the current beat.
// ----------------------------------------------------------------------------
module bga_blink (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  bga_pkg::in_t  item,
  input  bga_pkg::cfg_t cfg,
  output logic          lamp_nxt
);

  logic       active_r, active_nxt;
  logic [7:0] countdown_r, countdown_nxt;
  logic       lamp_r;

  // Next state for the blinker
  always_comb begin
    active_nxt    = active_r;
    countdown_nxt = countdown_r;
    lamp_nxt      = lamp_r;
    case (item.operation)
      bga_pkg::OP_TICK: begin
        if (active_r) begin
          if (countdown_r <= 8'd1) begin
            lamp_nxt      = ~lamp_r;
            countdown_nxt = cfg.blink_half_period;
          end else begin
            countdown_nxt = countdown_r - 8'd1;
          end
        end
      end
      bga_pkg::OP_ALARM_START: begin
        active_nxt    = 1'b1;
        lamp_nxt      = 1'b0;
        countdown_nxt = cfg.blink_half_period;
      end
      bga_pkg::OP_ALARM_STOP: begin
        active_nxt = 1'b0;
        lamp_nxt   = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      countdown_r <= 8'd0;
      lamp_r      <= 1'b0;
    end else if (step) begin
      active_r    <= active_nxt;
      countdown_r <= countdown_nxt;
      lamp_r      <= lamp_nxt;
    end
  end

endmodule

// ===== rtl/core/button_gesture_and_alarm_blinker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_and_alarm_blinker
// Button gesture detector and alarm LED/buzzer blinker, one beat per command.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | bga_pkg::in_t
//   out_    | output    | out_valid/out_stall | bga_pkg::out_t
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One beat per cycle sustained while out_stall is low; a beat passes through the
// input register, then the result register. The state update for a beat happens
// as it leaves the input register, so consecutive beats see each other's results.
// Synchronous active-low reset clears control state and loads config defaults.
// out_stall holds the result register and, once the input register is also
// full, raises in_stall. cfg_ready is always high.
// ----------------------------------------------------------------------------
module button_gesture_and_alarm_blinker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bga_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bga_pkg::out_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bga_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                        cfg_data
);

  logic            stg_valid_r, stg_valid_nxt;
  bga_pkg::in_t    stg_data_r;
  logic            out_valid_r, out_valid_nxt;
  bga_pkg::out_t   out_data_r;
  bga_pkg::cfg_t   cfg_r;
  logic            stg_adv;
  logic            in_take;
  bga_pkg::key_e_t key_event_nxt;
  logic [7:0]      presses_nxt;
  logic            lamp_nxt;

  // Handshake control
  assign stg_adv       = stg_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall      = stg_valid_r & ~stg_adv;
  assign in_take       = in_valid & ~in_stall;
  assign stg_valid_nxt = in_take | (stg_valid_r & ~stg_adv);
  assign out_valid_nxt = stg_adv | (out_valid_r & out_stall);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) stg_data_r <= in_data;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_press_ticks      <= bga_pkg::RST_MIN_PRESS;
      cfg_r.long_press_ticks     <= bga_pkg::RST_LONG_PRESS;
      cfg_r.release_settle_ticks <= bga_pkg::RST_RELEASE_SETTLE;
      cfg_r.multi_press_count    <= bga_pkg::RST_MULTI_PRESS;
      cfg_r.blink_half_period    <= bga_pkg::RST_BLINK_HALF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bga_pkg::CFG_MIN_PRESS:      cfg_r.min_press_ticks      <= cfg_data;
        bga_pkg::CFG_LONG_PRESS:     cfg_r.long_press_ticks     <= cfg_data;
        bga_pkg::CFG_RELEASE_SETTLE: cfg_r.release_settle_ticks <= cfg_data;
        bga_pkg::CFG_MULTI_PRESS:    cfg_r.multi_press_count    <= cfg_data;
        bga_pkg::CFG_BLINK_HALF:     cfg_r.blink_half_period    <= cfg_data;
        default: ;
      endcase
    end
  end

  bga_gesture u_gesture (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (stg_adv),
    .item          (stg_data_r),
    .cfg           (cfg_r),
    .key_event_nxt (key_event_nxt),
    .presses_nxt   (presses_nxt)
  );

  bga_blink u_blink (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (stg_adv),
    .item     (stg_data_r),
    .cfg      (cfg_r),
    .lamp_nxt (lamp_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv) begin
      out_data_r.key_event   <= key_event_nxt;
      out_data_r.press_count <= presses_nxt;
      out_data_r.led_on      <= lamp_nxt;
      out_data_r.buzzer_on   <= lamp_nxt;
    end
  end

endmodule

// ===== rtl/core/bga_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bga_checker
// Port-level checks for the button gesture / alarm blinker, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bga_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input bga_pkg::out_t out_data
);

  // A held result beat stays put
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result beat changed while stalled")

  // LED and buzzer are driven from the same lamp bit
  `ASSERT_ALWAYS(a_lamp_pair, !out_valid || (out_data.led_on == out_data.buzzer_on), "LED and buzzer levels differ")

  // Input only backs up when the result register is full and stalled
  `ASSERT_ALWAYS(a_stall_cause, !in_stall || (out_valid && out_stall), "input stalled with room downstream")

  // A beat taken while out_valid is low shows up as out_valid after the input register
  `ASSERT_NEXT(a_flow, in_valid && !in_stall && !out_valid, ##1 out_valid, "accepted beat never reached output")

endmodule

bind button_gesture_and_alarm_blinker bga_checker u_bga_checker (.*);

// ===== dv/button_gesture_and_alarm_blinker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_and_alarm_blinker_tb
// Self-checking bench for the button gesture detector and alarm blinker.
// A queue-fed driver sends command beats with random gaps, and the result side
// stalls at random. Every accepted beat runs through a local model of the
// gesture and blink logic. Each result is then checked against the oldest
// predicted status. The register settings change between phases while the
// block is idle. A short directed opening covers the corners, then randomized
// press sequences and commands follow.
// ----------------------------------------------------------------------------
module button_gesture_and_alarm_blinker_tb;
  import bga_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_BEATS    = 90;
  localparam int RANDOM_PHASES  = 2;

  // DUT ports
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = '0;

  // Shadow registers and gesture/blink state
  cfg_t       regs;
  logic       btn_down;
  logic [7:0] hold_len;
  logic [7:0] idle_len;
  logic [7:0] press_tally;
  key_e_t     gesture;
  logic       alarm_on;
  logic [7:0] blink_left;
  logic       lamp;

  // Pending command beats and predicted statuses
  in_t  beat_q[$];
  out_t status_q[$];
  int   queued_beats = 0;
  int   taken_beats  = 0;
  int   mismatches   = 0;
  int   quiet_cycles = 0;
  int   in_gap       = 0;
  int   out_hold     = 0;
  bit   in_fire      = 1'b0;
  bit   out_fire     = 1'b0;
  bit   no_idle      = 1'b0;

  button_gesture_and_alarm_blinker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Saturating counter step
  function automatic logic [7:0] bump8(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  // Apply one command beat to the local state and return the status it shows
  function automatic out_t next_status(input in_t b);
    out_t s;
    case (b.operation)
      OP_TICK: begin
        if (!b.button_low) begin
          hold_len = btn_down ? bump8(hold_len) : 8'd1;
          btn_down = 1'b1;
        end else begin
          if (btn_down) begin
            if (hold_len > regs.min_press_ticks) press_tally = bump8(press_tally);
            idle_len = 8'd0;
          end else begin
            idle_len = bump8(idle_len);
            // release has settled: classify the gesture
            if (idle_len > regs.release_settle_ticks) begin
              if (hold_len > regs.long_press_ticks) begin
                gesture  = KEY_LONG;
                hold_len = 8'd0;
              end else begin
                if (press_tally == 8'd1) gesture = KEY_SINGLE;
                if (press_tally >= regs.multi_press_count) gesture = KEY_MULTI;
              end
              idle_len = bump8(regs.release_settle_ticks);
            end
          end
          btn_down = 1'b0;
        end
        // blink countdown runs only while the alarm is on
        if (alarm_on) begin
          if (blink_left <= 8'd1) begin
            lamp       = ~lamp;
            blink_left = regs.blink_half_period;
          end else begin
            blink_left = blink_left - 8'd1;
          end
        end
      end
      OP_CONSUME: begin
        gesture = KEY_NONE;
        if (b.clear_count) press_tally = 8'd0;
      end
      OP_ALARM_START: begin
        alarm_on   = 1'b1;
        lamp       = 1'b0;
        blink_left = regs.blink_half_period;
      end
      default: begin
        alarm_on = 1'b0;
        lamp     = 1'b0;
      end
    endcase
    s.key_event   = gesture;
    s.press_count = press_tally;
    s.led_on      = lamp;
    s.buzzer_on   = lamp;
    return s;
  endfunction

  // Wait cycles for one beat on either side
  function automatic int pick_wait();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic void add_beat(input op_e_t op, input logic lvl, input logic clr);
    in_t b;
    b.operation   = op;
    b.button_low  = lvl;
    b.clear_count = clr;
    beat_q.push_back(b);
    queued_beats++;
  endfunction

  // Ticks with a fixed button level; clear_count is don't-care on a tick
  function automatic void add_ticks(input logic lvl, input int n);
    repeat (n) add_beat(OP_TICK, lvl, 1'($urandom_range(0, 1)));
  endfunction

  function automatic void add_press(input int hold, input int rel);
    add_ticks(1'b0, hold);
    add_ticks(1'b1, rel);
  endfunction

  // Register pick: half the time a small value, else an extreme or anything
  function automatic logic [7:0] pick_reg(input int lo, input int hi,
                                          input int top_small);
    case ($urandom_range(0, 5))
      0:       return 8'(lo);
      1:       return 8'(hi);
      2:       return 8'($urandom_range(lo, hi));
      default: return 8'($urandom_range(lo, top_small));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [7:0] min_p, input logic [7:0] long_p,
                           input logic [7:0] settle, input logic [7:0] multi,
                           input logic [7:0] half);
    write_reg(CFG_MIN_PRESS, min_p);
    write_reg(CFG_LONG_PRESS, long_p);
    write_reg(CFG_RELEASE_SETTLE, settle);
    write_reg(CFG_MULTI_PRESS, multi);
    write_reg(CFG_BLINK_HALF, half);
  endtask

  // Block until every queued beat is in and every status has come back
  task automatic drain();
    while (taken_beats != queued_beats || status_q.size() != 0) @(posedge clk);
  endtask

  // Command driver: holds a beat while stalled, gaps between beats
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (beat_q.size() != 0) begin
        in_data  <= beat_q.pop_front();
        in_valid <= 1'b1;
        in_gap   = pick_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side stall: a fresh hold-off after each accepted result
  always @(negedge clk) begin
    if (out_fire) out_hold = pick_wait();
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on input beats, check result beats, track config writes
  always @(posedge clk) begin : monitor
    out_t want;
    bit   busy;
    in_fire  <= rst_n && in_valid && !in_stall;
    out_fire <= rst_n && out_valid && !out_stall;
    if (rst_n) begin
      busy = 1'b0;
      if (cfg_valid && cfg_ready) begin
        busy = 1'b1;
        case (cfg_index)
          CFG_MIN_PRESS:      regs.min_press_ticks      = cfg_data;
          CFG_LONG_PRESS:     regs.long_press_ticks     = cfg_data;
          CFG_RELEASE_SETTLE: regs.release_settle_ticks = cfg_data;
          CFG_MULTI_PRESS:    regs.multi_press_count    = cfg_data;
          CFG_BLINK_HALF:     regs.blink_half_period    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        busy = 1'b1;
        status_q.push_back(next_status(in_data));
        taken_beats++;
      end
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result beat: key %0d count %0d led %b buzzer %b",
                     out_data.key_event, out_data.press_count,
                     out_data.led_on, out_data.buzzer_on);
        end else begin
          want = status_q.pop_front();
          if (out_data.key_event !== want.key_event ||
              out_data.press_count !== want.press_count ||
              out_data.led_on !== want.led_on ||
              out_data.buzzer_on !== want.buzzer_on) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch at %0t: key %0d/%0d count %0d/%0d led %b/%b buzzer %b/%b %s",
                       $realtime, want.key_event, out_data.key_event,
                       want.press_count, out_data.press_count,
                       want.led_on, out_data.led_on,
                       want.buzzer_on, out_data.buzzer_on, "(expected/actual)");
          end
        end
      end
      // watchdog on cycles without any accepted beat or config write
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("button_gesture_and_alarm_blinker regression: fail");
        $finish;
      end
    end
  end

  // Stimulus sequence
  initial begin : stimulus
    logic [7:0] min_p, long_p, settle, multi, half;
    int         start, r, hold_top;

    regs.min_press_ticks      = RST_MIN_PRESS;
    regs.long_press_ticks     = RST_LONG_PRESS;
    regs.release_settle_ticks = RST_RELEASE_SETTLE;
    regs.multi_press_count    = RST_MULTI_PRESS;
    regs.blink_half_period    = RST_BLINK_HALF;
    btn_down    = 1'b0;
    hold_len    = 8'd0;
    idle_len    = 8'd0;
    press_tally = 8'd0;
    gesture     = KEY_NONE;
    alarm_on    = 1'b0;
    blink_left  = 8'd0;
    lamp        = 1'b0;

    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults: stop while idle, consume with clear, a released tick
    add_beat(OP_ALARM_STOP, 1'b1, 1'b0);
    add_beat(OP_CONSUME, 1'b0, 1'b1);
    add_ticks(1'b1, 1);
    drain();

    // Short timings so gestures resolve within a few beats
    write_all(8'd1, 8'd4, 8'd1, 8'd2, 8'd2);
    add_press(3, 3);                        // single press
    add_beat(OP_CONSUME, 1'b1, 1'b0);       // consume, keep the count
    add_press(6, 3);                        // long press overrides
    add_beat(OP_CONSUME, 1'b0, 1'b1);
    add_beat(OP_ALARM_START, 1'b0, 1'b0);
    add_ticks(1'b1, 3);
    add_beat(OP_ALARM_START, 1'b1, 1'b1);   // restart while blinking
    add_ticks(1'b1, 2);
    add_beat(OP_ALARM_STOP, 1'b0, 1'b1);
    add_ticks(1'b1, 1);
    drain();

    // Below-range multi count and zero half period
    write_all(8'd1, 8'd4, 8'd0, 8'd0, 8'd0);
    add_beat(OP_ALARM_START, 1'b1, 1'b0);
    add_ticks(1'b1, 3);                     // multi with no presses, toggle per tick
    add_beat(OP_CONSUME, 1'b1, 1'b1);
    drain();
    write_reg(CFG_MULTI_PRESS, 8'd1);
    add_press(2, 2);                        // one press reports multi
    add_beat(OP_ALARM_STOP, 1'b1, 1'b0);
    drain();

    // Saturation: press count at top settings
    no_idle = 1'b1;
    write_all(8'd0, 8'd254, 8'd254, 8'd255, 8'd255);
    add_beat(OP_CONSUME, 1'b0, 1'b1);
    add_beat(OP_ALARM_START, 1'b0, 1'b0);
    repeat (256) add_press(1, 1);
    add_beat(OP_ALARM_STOP, 1'b0, 1'b0);
    drain();

    // Randomized phases: mostly well-formed presses, some commands and noise
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      min_p  = pick_reg(0, 255, 3);
      long_p = pick_reg(0, 255, 10);
      settle = pick_reg(0, 6, 4);
      multi  = pick_reg(2, 255, 4);
      half   = pick_reg(1, 255, 5);
      write_all(min_p, long_p, settle, multi, half);
      hold_top = (long_p < 8'd12) ? int'(long_p) + 3 : 14;
      start = queued_beats;
      while (queued_beats - start < PHASE_BEATS) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          if ($urandom_range(0, 1) == 0)
            add_press($urandom_range(1, hold_top),
                      int'(settle) + 1 + $urandom_range(0, 2));
          else
            add_press($urandom_range(1, hold_top), $urandom_range(1, int'(settle) + 1));
        end else if (r < 75) begin
          add_beat(OP_CONSUME, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (r < 85) begin
          add_beat(($urandom_range(0, 1) == 0) ? OP_ALARM_START : OP_ALARM_STOP,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          add_beat(op_e_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        end
      end
      drain();
    end

    // Tail for the two-stage pipeline
    repeat (4) @(posedge clk);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("button_gesture_and_alarm_blinker regression: pass");
    end else begin
      $display("button_gesture_and_alarm_blinker regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/bga_pkg.sv
rtl/core/bga_gesture.sv
rtl/core/bga_blink.sv
rtl/core/button_gesture_and_alarm_blinker.sv
rtl/core/bga_checker.sv
dv/button_gesture_and_alarm_blinker_tb.sv
